// ===== design/cst_pkg.sv =====
package cst_pkg;

   localparam int MAX_TEXT_DEF = 256;
   localparam int TEXT_LEN_W = 12;
   localparam int LINE_W = 24;
   localparam logic [LINE_W-1:0] LINE_TOP = '1;
   localparam int RES_MAX = 4;
   localparam int RSPQ_DEPTH = 8;

   // token codes above the single-byte range
   localparam logic [8:0] TOK_KW0   = 9'd256;
   localparam logic [8:0] TOK_INC   = 9'd284;
   localparam logic [8:0] TOK_DEC   = 9'd285;
   localparam logic [8:0] TOK_ADDA  = 9'd286;
   localparam logic [8:0] TOK_SUBA  = 9'd287;
   localparam logic [8:0] TOK_MULA  = 9'd288;
   localparam logic [8:0] TOK_DIVA  = 9'd289;
   localparam logic [8:0] TOK_MODA  = 9'd290;
   localparam logic [8:0] TOK_PTR   = 9'd291;
   localparam logic [8:0] TOK_EQ    = 9'd292;
   localparam logic [8:0] TOK_NE    = 9'd293;
   localparam logic [8:0] TOK_LE    = 9'd294;
   localparam logic [8:0] TOK_GE    = 9'd295;
   localparam logic [8:0] TOK_SHL   = 9'd296;
   localparam logic [8:0] TOK_SHR   = 9'd297;
   localparam logic [8:0] TOK_SHLA  = 9'd298;
   localparam logic [8:0] TOK_SHRA  = 9'd299;
   localparam logic [8:0] TOK_LAND  = 9'd300;
   localparam logic [8:0] TOK_LOR   = 9'd301;
   localparam logic [8:0] TOK_ANDA  = 9'd302;
   localparam logic [8:0] TOK_ORA   = 9'd303;
   localparam logic [8:0] TOK_XORA  = 9'd304;
   localparam logic [8:0] TOK_DOTS  = 9'd305;
   localparam logic [8:0] TOK_NAME  = 9'd306;
   localparam logic [8:0] TOK_INT   = 9'd307;
   localparam logic [8:0] TOK_FLT   = 9'd308;
   localparam logic [8:0] TOK_STR   = 9'd309;
   localparam logic [8:0] TOK_EOF   = 9'd310;
   localparam int KW_COUNT = 28;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_DQ  = 8'h22;
   localparam logic [7:0] CH_SQ  = 8'h27;
   localparam logic [7:0] CH_BSL = 8'h5C;

   typedef enum logic [1:0] {
      KIND_TOKEN = 2'd0,
      KIND_TEXT  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_SLASH, MODE_OPER, MODE_IDENT, MODE_NZERO, MODE_NINT,
      MODE_NFRAC, MODE_NEXPS, MODE_NEXPD, MODE_STR, MODE_ESC, MODE_HEX1,
      MODE_HEX2, MODE_LCOM, MODE_BCOM, MODE_BSTAR
   } mode_type;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_OCT = 2'd1,
      BASE_HEX = 2'd2
   } base_type;

   typedef struct packed {
      kind_type          kind;
      logic [8:0]        code;
      logic [63:0]       value;
      logic [7:0]        ch;
      logic [LINE_W-1:0] line;
      logic              last;
   } res_type;

   typedef struct packed {
      mode_type              mode;
      logic [63:0]           acc;
      base_type              base;
      logic [7:0]            pend;
      logic [1:0]            stage;
      logic [63:0]           kw;
      logic [TEXT_LEN_W-1:0] tlen;
      logic [LINE_W-1:0]     line;
      logic [3:0]            esc;
      logic                  quote;
      logic [7:0]            first;
      logic                  flt;
   } lex_st_type;

   typedef struct packed {
      res_type [RES_MAX-1:0] r;
      logic [2:0]            n;
   } res_set_type;

   typedef struct packed {
      lex_st_type  st;
      res_set_type o;
      logic        redo;
   } work_type;

   function automatic work_type put(work_type w, kind_type kind, logic [8:0] code,
                                    logic [63:0] val, logic [7:0] ch);
      res_type x;
      x.kind  = kind;
      x.code  = code;
      x.value = val;
      x.ch    = ch;
      x.line  = w.st.line;
      x.last  = 1'b0;
      if (w.o.n < 3'(RES_MAX)) begin
         w.o.r[w.o.n[1:0]] = x;
         w.o.n = w.o.n + 3'd1;
      end
      return w;
   endfunction

   function automatic work_type put_tok(work_type w, logic [8:0] code);
      return put(w, KIND_TOKEN, code, 64'd0, 8'd0);
   endfunction

   function automatic work_type new_line(work_type w);
      if (w.st.line != LINE_TOP) w.st.line = w.st.line + 1'b1;
      return w;
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_of(logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (is_num(c)) begin
         t = c - "0";
         return {1'b1, t[3:0]};
      end
      if (c >= "a" && c <= "f") begin
         t = c - "a" + 8'd10;
         return {1'b1, t[3:0]};
      end
      if (c >= "A" && c <= "F") begin
         t = c - "A" + 8'd10;
         return {1'b1, t[3:0]};
      end
      return 5'd0;
   endfunction

   // {length, name right-aligned}
   function automatic logic [67:0] kw_entry(int k);
      unique case (k)
         0:  return {4'd3, 64'("int")};
         1:  return {4'd4, 64'("char")};
         2:  return {4'd4, 64'("void")};
         3:  return {4'd2, 64'("if")};
         4:  return {4'd4, 64'("else")};
         5:  return {4'd5, 64'("while")};
         6:  return {4'd3, 64'("for")};
         7:  return {4'd2, 64'("do")};
         8:  return {4'd6, 64'("return")};
         9:  return {4'd5, 64'("break")};
         10: return {4'd8, 64'("continue")};
         11: return {4'd6, 64'("switch")};
         12: return {4'd4, 64'("case")};
         13: return {4'd7, 64'("default")};
         14: return {4'd6, 64'("sizeof")};
         15: return {4'd6, 64'("struct")};
         16: return {4'd5, 64'("union")};
         17: return {4'd4, 64'("enum")};
         18: return {4'd7, 64'("typedef")};
         19: return {4'd6, 64'("static")};
         20: return {4'd6, 64'("extern")};
         21: return {4'd5, 64'("const")};
         22: return {4'd8, 64'("unsigned")};
         23: return {4'd6, 64'("signed")};
         24: return {4'd5, 64'("short")};
         25: return {4'd4, 64'("long")};
         26: return {4'd5, 64'("float")};
         27: return {4'd6, 64'("double")};
         default: return 68'd0;
      endcase
   endfunction

   function automatic work_type start_text(work_type w);
      w.st.tlen  = '0;
      w.st.kw    = 64'd0;
      w.st.first = 8'd0;
      return w;
   endfunction

   function automatic work_type store_text(work_type w, logic [7:0] c, logic vis,
                                           logic [TEXT_LEN_W-1:0] lim);
      if (w.st.tlen < lim) begin
         if (w.st.tlen == '0) w.st.first = c;
         if (w.st.tlen < TEXT_LEN_W'(8)) w.st.kw = {w.st.kw[55:0], c};
         if (vis) w = put(w, KIND_TEXT, 9'd0, 64'd0, c);
         w.st.tlen = w.st.tlen + 1'b1;
      end
      return w;
   endfunction

   function automatic work_type end_ident(work_type w);
      logic [8:0]  code;
      logic [67:0] e;
      code = TOK_NAME;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         e = kw_entry(k);
         if (w.st.tlen == TEXT_LEN_W'(e[67:64]) && w.st.kw == e[63:0])
            code = TOK_KW0 + 9'(k);
      end
      return put_tok(w, code);
   endfunction

   function automatic work_type end_number(work_type w);
      return put(w, KIND_TOKEN, w.st.flt ? TOK_FLT : TOK_INT, w.st.acc, 8'd0);
   endfunction

   function automatic work_type end_string(work_type w);
      if (!w.st.quote) return put_tok(w, TOK_STR);
      return put(w, KIND_TOKEN, TOK_INT, {{56{w.st.first[7]}}, w.st.first}, 8'd0);
   endfunction

   function automatic logic [8:0] op_pair(logic [7:0] p, logic [7:0] c);
      unique case (p)
         "+": return c == "+" ? TOK_INC : c == "=" ? TOK_ADDA : 9'd0;
         "-": return c == "-" ? TOK_DEC : c == "=" ? TOK_SUBA :
                     c == ">" ? TOK_PTR : 9'd0;
         "*": return c == "=" ? TOK_MULA : 9'd0;
         "%": return c == "=" ? TOK_MODA : 9'd0;
         "=": return c == "=" ? TOK_EQ : 9'd0;
         "!": return c == "=" ? TOK_NE : 9'd0;
         "<": return c == "=" ? TOK_LE : 9'd0;
         ">": return c == "=" ? TOK_GE : 9'd0;
         "&": return c == "&" ? TOK_LAND : c == "=" ? TOK_ANDA : 9'd0;
         "|": return c == "|" ? TOK_LOR : c == "=" ? TOK_ORA : 9'd0;
         "^": return c == "=" ? TOK_XORA : 9'd0;
         default: return 9'd0;
      endcase
   endfunction

   function automatic work_type after_int(work_type w, logic [7:0] c,
                                          logic [TEXT_LEN_W-1:0] lim);
      if (c == ".") begin
         w.st.flt = 1'b1;
         w = store_text(w, c, 1'b1, lim);
         w.st.mode = MODE_NFRAC;
      end else if (c == "e" || c == "E") begin
         w.st.flt = 1'b1;
         w = store_text(w, c, 1'b1, lim);
         w.st.mode = MODE_NEXPS;
      end else begin
         w = end_number(w);
         w.st.mode = MODE_IDLE;
         w.redo = 1'b1;
      end
      return w;
   endfunction

   function automatic work_type idle_byte(work_type w, logic [7:0] c,
                                          logic [TEXT_LEN_W-1:0] lim);
      w.st.mode = MODE_IDLE;
      if (c == " " || c == CH_TAB || c == CH_CR) begin
         return w;
      end
      if (c == CH_LF) return new_line(w);
      if (c == "/") begin
         w.st.mode = MODE_SLASH;
         return w;
      end
      if (is_alpha(c)) begin
         w = start_text(w);
         w.st.mode = MODE_IDENT;
         return store_text(w, c, 1'b1, lim);
      end
      if (is_num(c)) begin
         w = start_text(w);
         w.st.flt  = 1'b0;
         w.st.base = BASE_DEC;
         w.st.acc  = 64'(c - "0");
         w.st.mode = (c == "0") ? MODE_NZERO : MODE_NINT;
         return w;
      end
      if (c == CH_DQ || c == CH_SQ) begin
         w = start_text(w);
         w.st.quote = (c == CH_SQ);
         w.st.mode  = MODE_STR;
         return w;
      end
      if (c == "+" || c == "-" || c == "*" || c == "%" || c == "=" || c == "!" ||
          c == "<" || c == ">" || c == "&" || c == "|" || c == "^" || c == ".") begin
         w.st.pend  = c;
         w.st.stage = 2'd1;
         w.st.mode  = MODE_OPER;
         return w;
      end
      return put_tok(w, {1'b0, c});
   endfunction

   // One visit of the byte in the current mode; redo asks for another visit.
   function automatic work_type lex_pass(work_type w, logic [7:0] c,
                                         logic [TEXT_LEN_W-1:0] lim);
      logic [4:0] hv;
      logic [8:0] code;
      logic [7:0] dc;
      logic [63:0] sc;
      hv   = hex_of(c);
      code = op_pair(w.st.pend, c);
      dc   = c;
      sc   = 64'd0;
      w.redo = 1'b0;
      unique case (w.st.mode)
         MODE_IDLE: w = idle_byte(w, c, lim);
         MODE_SLASH: begin
            w.st.mode = MODE_IDLE;
            if (c == "/") w.st.mode = MODE_LCOM;
            else if (c == "*") w.st.mode = MODE_BCOM;
            else if (c == "=") w = put_tok(w, TOK_DIVA);
            else begin
               w = put_tok(w, 9'({"/"}));
               w.redo = 1'b1;
            end
         end
         MODE_OPER: begin
            if (w.st.stage == 2'd2) begin
               w.st.mode  = MODE_IDLE;
               w.st.stage = 2'd0;
               if (w.st.pend == ".") begin
                  if (c == ".") w = put_tok(w, TOK_DOTS);
                  else begin
                     w = put_tok(w, 9'({"."}));
                     w = put_tok(w, 9'({"."}));
                     w.redo = 1'b1;
                  end
               end else if (c == "=") begin
                  w = put_tok(w, w.st.pend == "<" ? TOK_SHLA : TOK_SHRA);
               end else begin
                  w = put_tok(w, w.st.pend == "<" ? TOK_SHL : TOK_SHR);
                  w.redo = 1'b1;
               end
            end else if ((w.st.pend == "<" || w.st.pend == ">" || w.st.pend == ".") &&
                         c == w.st.pend) begin
               w.st.stage = 2'd2;
            end else begin
               w.st.mode  = MODE_IDLE;
               w.st.stage = 2'd0;
               if (code != 9'd0) w = put_tok(w, code);
               else begin
                  w = put_tok(w, {1'b0, w.st.pend});
                  w.redo = 1'b1;
               end
            end
         end
         MODE_IDENT: begin
            if (is_alpha(c) || is_num(c)) w = store_text(w, c, 1'b1, lim);
            else begin
               w = end_ident(w);
               w.st.mode = MODE_IDLE;
               w.redo = 1'b1;
            end
         end
         MODE_NZERO: begin
            w.st.acc = 64'd0;
            if (c == "x" || c == "X") begin
               w.st.base = BASE_HEX;
               w.st.mode = MODE_NINT;
            end else if (is_num(c)) begin
               w.st.base = BASE_OCT;
               w.st.mode = MODE_NINT;
               w.redo = 1'b1;
            end else w = after_int(w, c, lim);
         end
         MODE_NINT: begin
            if (w.st.base == BASE_HEX ? hv[4] :
                w.st.base == BASE_OCT ? (c >= "0" && c <= "7") : is_num(c)) begin
               unique case (w.st.base)
                  BASE_HEX: sc = {w.st.acc[59:0], 4'd0};
                  BASE_OCT: sc = {w.st.acc[60:0], 3'd0};
                  default:  sc = {w.st.acc[60:0], 3'd0} + {w.st.acc[62:0], 1'b0};
               endcase
               w.st.acc = sc + 64'(hv[3:0]);
            end else w = after_int(w, c, lim);
         end
         MODE_NFRAC: begin
            if (is_num(c)) w = store_text(w, c, 1'b1, lim);
            else if (c == "e" || c == "E") begin
               w = store_text(w, c, 1'b1, lim);
               w.st.mode = MODE_NEXPS;
            end else begin
               w = end_number(w);
               w.st.mode = MODE_IDLE;
               w.redo = 1'b1;
            end
         end
         MODE_NEXPS: begin
            if (c == "+" || c == "-" || is_num(c)) begin
               w = store_text(w, c, 1'b1, lim);
               w.st.mode = MODE_NEXPD;
            end else begin
               w = end_number(w);
               w.st.mode = MODE_IDLE;
               w.redo = 1'b1;
            end
         end
         MODE_NEXPD: begin
            if (is_num(c)) w = store_text(w, c, 1'b1, lim);
            else begin
               w = end_number(w);
               w.st.mode = MODE_IDLE;
               w.redo = 1'b1;
            end
         end
         MODE_STR: begin
            if (c == (w.st.quote ? CH_SQ : CH_DQ)) begin
               w = end_string(w);
               w.st.mode = MODE_IDLE;
            end else if (c == CH_LF) begin
               w = put(w, KIND_ERROR, 9'd0, 64'd0, 8'd0);
               w = end_string(w);
               w = new_line(w);
               w.st.mode = MODE_IDLE;
            end else if (c == CH_BSL) w.st.mode = MODE_ESC;
            else w = store_text(w, c, !w.st.quote, lim);
         end
         MODE_ESC: begin
            w.st.mode = MODE_STR;
            if (c == "x") begin
               w.st.esc  = 4'd0;
               w.st.mode = MODE_HEX1;
            end else begin
               if (c == CH_LF) w = new_line(w);
               if (c == "n") dc = CH_LF;
               else if (c == "t") dc = CH_TAB;
               else if (c == "r") dc = CH_CR;
               else if (c == "0") dc = 8'd0;
               w = store_text(w, dc, !w.st.quote, lim);
            end
         end
         MODE_HEX1: begin
            if (hv[4]) begin
               w.st.esc  = hv[3:0];
               w.st.mode = MODE_HEX2;
            end else begin
               w = store_text(w, 8'd0, !w.st.quote, lim);
               w.st.mode = MODE_STR;
               w.redo = 1'b1;
            end
         end
         MODE_HEX2: begin
            w.st.mode = MODE_STR;
            if (hv[4]) w = store_text(w, {w.st.esc, hv[3:0]}, !w.st.quote, lim);
            else begin
               w = store_text(w, {4'd0, w.st.esc}, !w.st.quote, lim);
               w.redo = 1'b1;
            end
         end
         MODE_LCOM: begin
            if (c == CH_LF) begin
               w = new_line(w);
               w.st.mode = MODE_IDLE;
            end
         end
         MODE_BCOM: begin
            if (c == CH_LF) w = new_line(w);
            else if (c == "*") w.st.mode = MODE_BSTAR;
         end
         MODE_BSTAR: begin
            if (c == "/") w.st.mode = MODE_IDLE;
            else if (c == CH_LF) begin
               w = new_line(w);
               w.st.mode = MODE_BCOM;
            end else if (c != "*") w.st.mode = MODE_BCOM;
         end
      endcase
      return w;
   endfunction

   function automatic work_type lex_flush(work_type w, logic [TEXT_LEN_W-1:0] lim);
      unique case (w.st.mode)
         MODE_SLASH: w = put_tok(w, 9'({"/"}));
         MODE_OPER: begin
            if (w.st.stage == 2'd2) begin
               if (w.st.pend == ".") begin
                  w = put_tok(w, 9'({"."}));
                  w = put_tok(w, 9'({"."}));
               end else w = put_tok(w, w.st.pend == "<" ? TOK_SHL : TOK_SHR);
            end else w = put_tok(w, {1'b0, w.st.pend});
         end
         MODE_IDENT: w = end_ident(w);
         MODE_NZERO, MODE_NINT, MODE_NFRAC, MODE_NEXPS, MODE_NEXPD:
            w = end_number(w);
         MODE_HEX1, MODE_HEX2: begin
            w = store_text(w, w.st.mode == MODE_HEX1 ? 8'd0 : {4'd0, w.st.esc},
                           !w.st.quote, lim);
            w = put(w, KIND_ERROR, 9'd0, 64'd0, 8'd0);
            w = end_string(w);
         end
         MODE_STR, MODE_ESC: begin
            w = put(w, KIND_ERROR, 9'd0, 64'd0, 8'd0);
            w = end_string(w);
         end
         default: ;
      endcase
      w.st.mode  = MODE_IDLE;
      w.st.stage = 2'd0;
      w.st.pend  = 8'd0;
      return put_tok(w, TOK_EOF);
   endfunction

endpackage

// ===== design/cst_lex.sv =====
module cst_lex #(
   parameter int MAX_TEXT = cst_pkg::MAX_TEXT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           src_byte,
   input  logic                 src_end,
   output cst_pkg::res_set_type push_set
);

   localparam logic [cst_pkg::TEXT_LEN_W-1:0] LIM = cst_pkg::TEXT_LEN_W'(MAX_TEXT - 1);

   // idle, decimal, line one, everything else clear
   localparam cst_pkg::lex_st_type ST_RESET = '{
      mode:    cst_pkg::MODE_IDLE,
      base:    cst_pkg::BASE_DEC,
      line:    cst_pkg::LINE_W'(1),
      default: '0
   };

   cst_pkg::lex_st_type st_ff, st_in;
   cst_pkg::work_type   w0, w1, w2, w3;

   // up to three visits: e.g. octal prefix, bad digit, then a fresh token
   always_comb begin
      w0      = '0;
      w0.st   = st_ff;
      w1      = w0;
      w2      = w0;
      w3      = w0;
      if (src_end) begin
         w3 = cst_pkg::lex_flush(w0, LIM);
      end else begin
         w1 = cst_pkg::lex_pass(w0, src_byte, LIM);
         w2 = w1.redo ? cst_pkg::lex_pass(w1, src_byte, LIM) : w1;
         w3 = w2.redo ? cst_pkg::lex_pass(w2, src_byte, LIM) : w2;
      end
   end

   // next state
   always_comb begin
      st_in = take ? w3.st : st_ff;
   end

   // results, last one flagged
   always_comb begin
      push_set = w3.o;
      if (!take) push_set.n = 3'd0;
      if (push_set.n != 3'd0) begin
         push_set.r[2'(push_set.n - 3'd1)].last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

// ===== design/cst_rspq.sv =====
module cst_rspq (
   input  logic                 clock,
   input  logic                 reset,
   input  cst_pkg::res_set_type push_set,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cst_pkg::res_type     out_res
);

   localparam int DEPTH = cst_pkg::RSPQ_DEPTH;
   localparam int PW = $clog2(DEPTH);
   localparam int CW = PW + 1;

   cst_pkg::res_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pop;

   assign pop       = (cnt_ff != '0) && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_res   = mem_ff[rd_ff];
   assign room      = (cnt_ff <= CW'(DEPTH - cst_pkg::RES_MAX));

   always_comb begin
      wr_in  = wr_ff + PW'(push_set.n);
      rd_in  = rd_ff + PW'(pop);
      cnt_in = cnt_ff + CW'(push_set.n) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < cst_pkg::RES_MAX; i++) begin
         if (3'(i) < push_set.n) mem_ff[wr_ff + PW'(i)] <= push_set.r[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== design/c_source_tokenizer.sv =====
// C source tokenizer. One source byte per transfer on req (req_tlast high
// marks end of input: the pending token is flushed and an end-of-file token
// follows). Blanks and comments are skipped, LF bytes count lines. Each input
// transfer yields zero to four results on rsp: tokens (rsp_tuser 0), text
// characters of identifiers, strings and float tails (1), and the
// unterminated-string error (2); rsp_tlast flags the last result of an input.
// An input byte is taken every cycle while the 8-entry result queue has room
// for four results, so the block sustains one byte per cycle as long as the
// sink drains one result per cycle; only bursts wider than that stall req,
// bounded by the single result port draining the queue. Results are written
// into the registered result queue before they appear on rsp.
module c_source_tokenizer #(
   parameter int MAX_TEXT = cst_pkg::MAX_TEXT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] source_byte
   input  logic          req_tlast,   // end_of_input
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,   // token_code, number_value, text_char,
                                      // line_number, zero fill
   output logic [1:0]    rsp_tuser,   // result_kind
   output logic          rsp_tlast    // last_of_run
);

   cst_pkg::res_set_type push_set;
   cst_pkg::res_type     head;
   logic                 room;
   logic                 take;

   assign req_tready = room;
   assign take       = req_tvalid && room;

   // lexer state and per-byte decode
   cst_lex #(
      .MAX_TEXT(MAX_TEXT)
   ) u_lex (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .src_byte (req_tdata),
      .src_end  (req_tlast),
      .push_set (push_set)
   );

   // result queue decouples bursts from the sink
   cst_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push_set  (push_set),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (head)
   );

   assign rsp_tdata = {7'd0, head.line, head.ch, head.value, head.code};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

// ===== tb/sv/tb_c_source_tokenizer.sv =====
module tb_c_source_tokenizer;

   typedef struct {
      cst_pkg::kind_type          kind;
      logic [8:0]                 code;
      logic [63:0]                value;
      logic [7:0]                 ch;
      logic [cst_pkg::LINE_W-1:0] line;
      logic                       last;
   } lex_res_type;

   // Scoreboard: a software lexer that predicts the results of each accepted
   // transfer, and a queue of the results still owed by the block.
   class token_scoreboard;
      cst_pkg::mode_type          mode;
      logic [63:0]                acc;
      cst_pkg::base_type          base;
      logic [7:0]                 pend_op;
      logic [1:0]                 op_stage;
      logic [63:0]                kw_win;
      int                         tlen;
      logic [cst_pkg::LINE_W-1:0] line_no;
      logic [7:0]                 esc_val;
      logic                       quote_sq;
      logic [7:0]                 first_ch;
      logic                       flt_seen;
      lex_res_type                step_res[$];
      lex_res_type                owed[$];
      string                      kw_list[cst_pkg::KW_COUNT];

      function new();
         kw_list = '{"int", "char", "void", "if", "else", "while", "for", "do",
                     "return", "break", "continue", "switch", "case", "default",
                     "sizeof", "struct", "union", "enum", "typedef", "static",
                     "extern", "const", "unsigned", "signed", "short", "long",
                     "float", "double"};
         mode = cst_pkg::MODE_IDLE; acc = 0; base = cst_pkg::BASE_DEC;
         pend_op = 0; op_stage = 0;
         kw_win = 0; tlen = 0; line_no = 1; esc_val = 0; quote_sq = 0;
         first_ch = 0; flt_seen = 0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function void put(cst_pkg::kind_type k, logic [8:0] c, logic [63:0] v,
                        logic [7:0] ch);
         lex_res_type r;
         r.kind = k; r.code = c; r.value = v; r.ch = ch; r.line = line_no; r.last = 0;
         if (step_res.size() < cst_pkg::RES_MAX) step_res.push_back(r);
      endfunction

      function void tok(logic [8:0] c);
         put(cst_pkg::KIND_TOKEN, c, 64'd0, 8'd0);
      endfunction

      function void bump_line();
         if (line_no != cst_pkg::LINE_TOP) line_no++;
      endfunction

      function bit is_alp(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
      endfunction

      function bit is_dig(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function int hex_val(logic [7:0] c);
         if (is_dig(c)) return int'(c) - 48;
         if (c >= "a" && c <= "f") return int'(c) - 87;
         if (c >= "A" && c <= "F") return int'(c) - 55;
         return -1;
      endfunction

      function void open_text();
         tlen = 0; kw_win = 0; first_ch = 0;
      endfunction

      function void keep(logic [7:0] c, bit vis);
         if (tlen < cst_pkg::MAX_TEXT_DEF - 1) begin
            if (tlen == 0) first_ch = c;
            if (tlen < 8) kw_win = {kw_win[55:0], c};
            if (vis) put(cst_pkg::KIND_TEXT, 9'd0, 64'd0, c);
            tlen++;
         end
      endfunction

      function void close_ident();
         logic [8:0]  code;
         logic [63:0] packed_name;
         code = cst_pkg::TOK_NAME;
         for (int k = 0; k < cst_pkg::KW_COUNT; k++) begin
            packed_name = 0;
            for (int n = 0; n < kw_list[k].len(); n++)
               packed_name = {packed_name[55:0], kw_list[k][n]};
            if (kw_list[k].len() == tlen && packed_name == kw_win) begin
               code = cst_pkg::TOK_KW0 + 9'(k);
               break;
            end
         end
         tok(code);
      endfunction

      function void close_number();
         put(cst_pkg::KIND_TOKEN, flt_seen ? cst_pkg::TOK_FLT : cst_pkg::TOK_INT,
             acc, 8'd0);
      endfunction

      function void close_quote();
         if (!quote_sq) tok(cst_pkg::TOK_STR);
         else put(cst_pkg::KIND_TOKEN, cst_pkg::TOK_INT, {{56{first_ch[7]}}, first_ch},
                  8'd0);
      endfunction

      function logic [8:0] pair_code(logic [7:0] p, logic [7:0] c);
         case (p)
            "+": return c == "+" ? cst_pkg::TOK_INC : c == "=" ? cst_pkg::TOK_ADDA : 9'd0;
            "-": return c == "-" ? cst_pkg::TOK_DEC : c == "=" ? cst_pkg::TOK_SUBA :
                        c == ">" ? cst_pkg::TOK_PTR : 9'd0;
            "*": return c == "=" ? cst_pkg::TOK_MULA : 9'd0;
            "%": return c == "=" ? cst_pkg::TOK_MODA : 9'd0;
            "=": return c == "=" ? cst_pkg::TOK_EQ : 9'd0;
            "!": return c == "=" ? cst_pkg::TOK_NE : 9'd0;
            "<": return c == "=" ? cst_pkg::TOK_LE : 9'd0;
            ">": return c == "=" ? cst_pkg::TOK_GE : 9'd0;
            "&": return c == "&" ? cst_pkg::TOK_LAND : c == "=" ? cst_pkg::TOK_ANDA : 9'd0;
            "|": return c == "|" ? cst_pkg::TOK_LOR : c == "=" ? cst_pkg::TOK_ORA : 9'd0;
            "^": return c == "=" ? cst_pkg::TOK_XORA : 9'd0;
            default: return 9'd0;
         endcase
      endfunction

      function bit past_int(logic [7:0] c);
         if (c == ".") begin
            flt_seen = 1; keep(c, 1); mode = cst_pkg::MODE_NFRAC; return 0;
         end
         if (c == "e" || c == "E") begin
            flt_seen = 1; keep(c, 1); mode = cst_pkg::MODE_NEXPS; return 0;
         end
         close_number();
         mode = cst_pkg::MODE_IDLE;
         return 1;
      endfunction

      function void from_idle(logic [7:0] c);
         mode = cst_pkg::MODE_IDLE;
         if (c == " " || c == cst_pkg::CH_TAB || c == cst_pkg::CH_CR) return;
         if (c == cst_pkg::CH_LF) begin bump_line(); return; end
         if (c == "/") begin mode = cst_pkg::MODE_SLASH; return; end
         if (is_alp(c)) begin
            open_text(); mode = cst_pkg::MODE_IDENT; keep(c, 1); return;
         end
         if (is_dig(c)) begin
            open_text(); flt_seen = 0; base = cst_pkg::BASE_DEC;
            acc = 64'(c - 8'h30);
            mode = (c == "0") ? cst_pkg::MODE_NZERO : cst_pkg::MODE_NINT;
            return;
         end
         if (c == cst_pkg::CH_DQ || c == cst_pkg::CH_SQ) begin
            open_text(); quote_sq = (c == cst_pkg::CH_SQ); mode = cst_pkg::MODE_STR;
            return;
         end
         if (c == "+" || c == "-" || c == "*" || c == "%" || c == "=" || c == "!" ||
             c == "<" || c == ">" || c == "&" || c == "|" || c == "^" || c == ".") begin
            pend_op = c; op_stage = 1; mode = cst_pkg::MODE_OPER; return;
         end
         tok({1'b0, c});
      endfunction

      // one look at the byte in the current mode; 1 means look again
      function bit visit(logic [7:0] c);
         int         d;
         logic [8:0] code;
         logic [63:0] mul;
         d = hex_val(c);
         case (mode)
            cst_pkg::MODE_SLASH: begin
               mode = cst_pkg::MODE_IDLE;
               if (c == "/") begin mode = cst_pkg::MODE_LCOM; return 0; end
               if (c == "*") begin mode = cst_pkg::MODE_BCOM; return 0; end
               if (c == "=") begin tok(cst_pkg::TOK_DIVA); return 0; end
               tok(9'({"/"}));
               return 1;
            end
            cst_pkg::MODE_OPER: begin
               if (op_stage == 2) begin
                  mode = cst_pkg::MODE_IDLE; op_stage = 0;
                  if (pend_op == ".") begin
                     if (c == ".") begin tok(cst_pkg::TOK_DOTS); return 0; end
                     tok(9'({"."})); tok(9'({"."}));
                     return 1;
                  end
                  if (c == "=") begin
                     tok(pend_op == "<" ? cst_pkg::TOK_SHLA : cst_pkg::TOK_SHRA); return 0;
                  end
                  tok(pend_op == "<" ? cst_pkg::TOK_SHL : cst_pkg::TOK_SHR);
                  return 1;
               end
               if ((pend_op == "<" || pend_op == ">" || pend_op == ".") && c == pend_op) begin
                  op_stage = 2; return 0;
               end
               mode = cst_pkg::MODE_IDLE; op_stage = 0;
               code = pair_code(pend_op, c);
               if (code != 0) begin tok(code); return 0; end
               tok({1'b0, pend_op});
               return 1;
            end
            cst_pkg::MODE_IDENT: begin
               if (is_alp(c) || is_dig(c)) begin keep(c, 1); return 0; end
               close_ident(); mode = cst_pkg::MODE_IDLE;
               return 1;
            end
            cst_pkg::MODE_NZERO: begin
               acc = 0;
               if (c == "x" || c == "X") begin
                  base = cst_pkg::BASE_HEX; mode = cst_pkg::MODE_NINT; return 0;
               end
               if (is_dig(c)) begin
                  base = cst_pkg::BASE_OCT; mode = cst_pkg::MODE_NINT; return 1;
               end
               return past_int(c);
            end
            cst_pkg::MODE_NINT: begin
               if (base == cst_pkg::BASE_HEX ? d >= 0 :
                   base == cst_pkg::BASE_OCT ? (c >= "0" && c <= "7") : is_dig(c)) begin
                  mul = base == cst_pkg::BASE_HEX ? 16 : base == cst_pkg::BASE_OCT ? 8 : 10;
                  acc = acc * mul + 64'(d);
                  return 0;
               end
               return past_int(c);
            end
            cst_pkg::MODE_NFRAC: begin
               if (is_dig(c)) begin keep(c, 1); return 0; end
               if (c == "e" || c == "E") begin
                  keep(c, 1); mode = cst_pkg::MODE_NEXPS; return 0;
               end
               close_number(); mode = cst_pkg::MODE_IDLE;
               return 1;
            end
            cst_pkg::MODE_NEXPS: begin
               if (c == "+" || c == "-" || is_dig(c)) begin
                  keep(c, 1); mode = cst_pkg::MODE_NEXPD; return 0;
               end
               close_number(); mode = cst_pkg::MODE_IDLE;
               return 1;
            end
            cst_pkg::MODE_NEXPD: begin
               if (is_dig(c)) begin keep(c, 1); return 0; end
               close_number(); mode = cst_pkg::MODE_IDLE;
               return 1;
            end
            cst_pkg::MODE_STR: begin
               if (c == (quote_sq ? cst_pkg::CH_SQ : cst_pkg::CH_DQ)) begin
                  close_quote(); mode = cst_pkg::MODE_IDLE; return 0;
               end
               if (c == cst_pkg::CH_LF) begin
                  put(cst_pkg::KIND_ERROR, 9'd0, 64'd0, 8'd0);
                  close_quote(); bump_line(); mode = cst_pkg::MODE_IDLE;
                  return 0;
               end
               if (c == cst_pkg::CH_BSL) begin mode = cst_pkg::MODE_ESC; return 0; end
               keep(c, !quote_sq);
               return 0;
            end
            cst_pkg::MODE_ESC: begin
               mode = cst_pkg::MODE_STR;
               if (c == "x") begin esc_val = 0; mode = cst_pkg::MODE_HEX1; return 0; end
               if (c == cst_pkg::CH_LF) bump_line();
               keep(c == "n" ? cst_pkg::CH_LF : c == "t" ? cst_pkg::CH_TAB :
                    c == "r" ? cst_pkg::CH_CR : c == "0" ? 8'd0 : c, !quote_sq);
               return 0;
            end
            cst_pkg::MODE_HEX1: begin
               if (d >= 0) begin esc_val = 8'(d); mode = cst_pkg::MODE_HEX2; return 0; end
               keep(8'd0, !quote_sq); mode = cst_pkg::MODE_STR;
               return 1;
            end
            cst_pkg::MODE_HEX2: begin
               mode = cst_pkg::MODE_STR;
               if (d >= 0) begin keep({esc_val[3:0], 4'(d)}, !quote_sq); return 0; end
               keep(esc_val, !quote_sq);
               return 1;
            end
            cst_pkg::MODE_LCOM: begin
               if (c == cst_pkg::CH_LF) begin bump_line(); mode = cst_pkg::MODE_IDLE; end
               return 0;
            end
            cst_pkg::MODE_BCOM: begin
               if (c == cst_pkg::CH_LF) bump_line();
               else if (c == "*") mode = cst_pkg::MODE_BSTAR;
               return 0;
            end
            cst_pkg::MODE_BSTAR: begin
               if (c == "/") mode = cst_pkg::MODE_IDLE;
               else if (c == cst_pkg::CH_LF) begin bump_line(); mode = cst_pkg::MODE_BCOM; end
               else if (c != "*") mode = cst_pkg::MODE_BCOM;
               return 0;
            end
            default: begin
               from_idle(c);
               return 0;
            end
         endcase
      endfunction

      function void end_of_input();
         case (mode)
            cst_pkg::MODE_SLASH: tok(9'({"/"}));
            cst_pkg::MODE_OPER: begin
               if (op_stage == 2) begin
                  if (pend_op == ".") begin tok(9'({"."})); tok(9'({"."})); end
                  else tok(pend_op == "<" ? cst_pkg::TOK_SHL : cst_pkg::TOK_SHR);
               end else tok({1'b0, pend_op});
            end
            cst_pkg::MODE_IDENT: close_ident();
            cst_pkg::MODE_NZERO, cst_pkg::MODE_NINT, cst_pkg::MODE_NFRAC,
            cst_pkg::MODE_NEXPS, cst_pkg::MODE_NEXPD: close_number();
            cst_pkg::MODE_HEX1, cst_pkg::MODE_HEX2: begin
               keep(mode == cst_pkg::MODE_HEX1 ? 8'd0 : esc_val, !quote_sq);
               put(cst_pkg::KIND_ERROR, 9'd0, 64'd0, 8'd0);
               close_quote();
            end
            cst_pkg::MODE_STR, cst_pkg::MODE_ESC: begin
               put(cst_pkg::KIND_ERROR, 9'd0, 64'd0, 8'd0);
               close_quote();
            end
            default: ;
         endcase
         mode = cst_pkg::MODE_IDLE; op_stage = 0; pend_op = 0;
         tok(cst_pkg::TOK_EOF);
      endfunction

      // accepted input transfer: predict its results
      function void note_input(logic [7:0] b, logic eoi);
         step_res.delete();
         if (eoi) end_of_input();
         else begin
            for (int g = 0; g < 4; g++) begin
               if (mode == cst_pkg::MODE_IDLE) begin from_idle(b); break; end
               if (!visit(b)) break;
            end
         end
         if (step_res.size() > 0) step_res[step_res.size()-1].last = 1;
         foreach (step_res[i]) owed.push_back(step_res[i]);
      endfunction

      // accepted result transfer: empty string when it matches
      function string check_result(lex_res_type got);
         lex_res_type w;
         if (owed.size() == 0)
            return $sformatf("unexpected result kind=%0d code=%0d", got.kind, got.code);
         w = owed.pop_front();
         if (got.kind !== w.kind || got.code !== w.code || got.value !== w.value ||
             got.ch !== w.ch || got.line !== w.line || got.last !== w.last)
            return $sformatf({"result mismatch: got k%0d c%0d v%h ch%h ln%0d l%0d, ",
                              "want k%0d c%0d v%h ch%h ln%0d l%0d"},
                             got.kind, got.code, got.value, got.ch, got.line, got.last,
                             w.kind, w.code, w.value, w.ch, w.line, w.last);
         return "";
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;    // [7:0] source_byte
   logic         req_tlast;    // end_of_input
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;    // [8:0] code, [72:9] value, [80:73] char, [104:81] line
   logic [1:0]   rsp_tuser;    // result kind
   logic         rsp_tlast;    // last result of an input

   token_scoreboard sb;
   int              errors;
   int              cyc;       // cycle count kept by the receiver
   logic [7:0]      bq[$];     // bytes of the snippet being built
   int              sent;

   c_source_tokenizer u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   task automatic report(string msg);
      $display("MISMATCH @%0d: %s", cyc, msg);
      errors++;
   endtask

   // Calm window: neither side idles. Hold window: the receiver holds off
   // so the result queue fills and req stalls.
   function automatic bit calm();
      return cyc >= 300 && cyc < 500;
   endfunction

   function automatic bit hold();
      return cyc >= 150 && cyc < 260;
   endfunction

   // One input transfer. Valid may drop for random idle cycles first.
   task automatic send(logic [7:0] b, logic eoi);
      while (!calm() && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(b, eoi);
      sent++;
   endtask

   task automatic send_queue();
      foreach (bq[i]) send(bq[i], 1'b0);
      bq.delete();
   endtask

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++) bq.push_back(s[i]);
   endfunction

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   function automatic void add_ident();
      string kws[6] = '{"continue", "unsigned", "sizeof", "typedef", "int", "do"};
      string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      if ($urandom_range(2) == 0) add_str(kws[$urandom_range(5)]);
      else if ($urandom_range(3) == 0)
         add_str(sb.kw_list[$urandom_range(cst_pkg::KW_COUNT - 1)]);
      else begin
         bq.push_back(pick("abcxyzQZ_"));
         repeat ($urandom_range(9)) bq.push_back(pick(alnum));
      end
   endfunction

   function automatic void add_number();
      case ($urandom_range(4))
         0: repeat ($urandom_range(1, 22)) bq.push_back(pick("0123456789"));
         1: begin
            add_str($urandom_range(1) ? "0x" : "0X");
            repeat ($urandom_range(0, 18)) bq.push_back(pick("0123456789abcdefABCDEF"));
         end
         2: begin
            bq.push_back("0");
            repeat ($urandom_range(1, 8)) bq.push_back(pick("0123456789"));
         end
         default: begin
            repeat ($urandom_range(1, 4)) bq.push_back(pick("0123456789"));
            if ($urandom_range(2) != 0) begin
               bq.push_back(".");
               repeat ($urandom_range(3)) bq.push_back(pick("0123456789"));
            end
            if ($urandom_range(1)) begin
               bq.push_back(pick("eE"));
               if ($urandom_range(1)) bq.push_back(pick("+-"));
               repeat ($urandom_range(3)) bq.push_back(pick("0123456789"));
            end
         end
      endcase
   endfunction

   function automatic void add_body_char(logic [7:0] q);
      case ($urandom_range(9))
         0: begin bq.push_back(cst_pkg::CH_BSL); bq.push_back(pick("ntr0\\'\"qx")); end
         1: begin
            bq.push_back(cst_pkg::CH_BSL); bq.push_back("x");
            repeat ($urandom_range(3)) bq.push_back(pick("09afAFg"));
         end
         2: bq.push_back(8'($urandom_range(128, 255)));
         3: if ($urandom_range(3) == 0) begin
            bq.push_back(cst_pkg::CH_BSL); bq.push_back(cst_pkg::CH_LF);
         end
         default: bq.push_back(8'($urandom_range(32, 126)) == q ? "a"
                               : (8'($urandom_range(32, 126))));
      endcase
   endfunction

   // Quoted literal; plain body bytes avoid the closing quote and backslash, but
   // add_body_char may give them too; LF only escaped or as an unterminated end.
   function automatic void add_quoted(logic [7:0] q, bit unterminated);
      logic [7:0] c;
      bq.push_back(q);
      repeat ($urandom_range(q == cst_pkg::CH_SQ ? 2 : 8)) begin
         if ($urandom_range(3) == 0) add_body_char(q);
         else begin
            c = 8'($urandom_range(32, 126));
            if (c == q || c == cst_pkg::CH_BSL) c = "k";
            bq.push_back(c);
         end
      end
      bq.push_back(unterminated ? cst_pkg::CH_LF : q);
   endfunction

   function automatic void add_operator();
      string ops[30] = '{"++", "--", "+=", "-=", "*=", "/=", "%=", "->", "==", "!=",
                         "<=", ">=", "<<", ">>", "<<=", ">>=", "&&", "||", "&=", "|=",
                         "^=", "...", "..", ".", "/", "<", ">", "!", "~", ";"};
      add_str(ops[$urandom_range(29)]);
   endfunction

   function automatic void add_comment();
      if ($urandom_range(1)) begin
         add_str("//");
         repeat ($urandom_range(6)) bq.push_back(pick("ab */\"x"));
         bq.push_back(cst_pkg::CH_LF);
      end else begin
         add_str("/*");
         repeat ($urandom_range(8)) bq.push_back(pick("a *\n/\"q"));
         add_str("*/");
      end
   endfunction

   // receiver: checks every result transfer and sets its own readiness
   initial begin
      lex_res_type got;
      string       msg;
      rsp_tready = 1'b0;
      cyc = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cyc++;
         if (rsp_tvalid && rsp_tready) begin
            got.kind  = cst_pkg::kind_type'(rsp_tuser);
            got.code  = rsp_tdata[8:0];
            got.value = rsp_tdata[72:9];
            got.ch    = rsp_tdata[80:73];
            got.line  = rsp_tdata[104:81];
            got.last  = rsp_tlast;
            msg = sb.check_result(got);
            if (msg != "") report(msg);
         end
         if (hold()) rsp_tready <= 1'b0;
         else if (calm()) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(99) >= 35);
      end
   end

   initial begin
      #3000000;
      $display("c_source_tokenizer verification failed");
      $finish;
   end

   initial begin
      int wait_cnt;
      sb = new();
      errors = 0;
      sent = 0;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tlast = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: keyword, hex, char escape, dots, string escapes, comment
      add_str("sizeof 0xff<<='\\x7'...\"s\\t\"08.5e+1//c\n");
      bq.push_back(8'hFF);
      send_queue();
      send(8'h00, 1'b1);
      add_str("'\\xF"); send_queue(); send(8'h41, 1'b1);   // pending hex escape at end

      // one identifier past the stored text limit
      bq.push_back("q");
      repeat (cst_pkg::MAX_TEXT_DEF + 4) bq.push_back("w");
      bq.push_back(" ");
      send_queue();

      while (sent < 420) begin
         case ($urandom_range(19))
            0, 1, 2:    add_ident();
            3, 4, 5:    add_number();
            6, 7:       add_quoted(cst_pkg::CH_DQ, $urandom_range(5) == 0);
            8:          add_quoted(cst_pkg::CH_SQ, $urandom_range(5) == 0);
            9, 10, 11:  add_operator();
            12:         add_comment();
            13:         bq.push_back(pick(" \t\r\n"));
            14:         bq.push_back(8'($urandom_range(255)));
            15:         add_str("/*");
            default:    ;
         endcase
         if ($urandom_range(1)) bq.push_back(pick(" \n(;"));
         send_queue();
         if ($urandom_range(24) == 0) send(8'($urandom_range(255)), 1'b1);
      end
      send(8'($urandom_range(255)), 1'b1);
      req_tvalid <= 1'b0;

      wait_cnt = 0;
      while (sb.pending() > 0 && wait_cnt < 20000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (20) @(posedge clock);
      if (sb.pending() > 0) report($sformatf("%0d results never arrived", sb.pending()));
      if (errors == 0) $display("c_source_tokenizer verification clean");
      else $display("c_source_tokenizer verification failed");
      $finish;
   end
endmodule
